@@ hw/rtl/psf_pkg.sv @@
`default_nettype none
package psf_pkg;

  // Grid geometry. The cell index on the ports is 12 bits wide, so the side stays at 16 or below.
  localparam int GRID_SIDE  = 16;
  localparam int PLANE      = GRID_SIDE * GRID_SIDE;
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COORD_W    = $clog2(GRID_SIDE);
  localparam int IDX_W      = 12;
  localparam int LAP_W      = 36;
  localparam int SUM_W      = 35;
  localparam int TDATA_W    = 112;
  localparam int CFG_IDX_W  = 3;

  localparam logic signed [31:0] Q_ONE  = 32'sd16777216;
  localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] val;
    logic               ovf;
  } satq_t;

  typedef struct packed {
    logic        [30:0] inv_sq;
    logic signed [31:0] triple;
    logic        [30:0] kappa;
    logic signed [31:0] mass;
    logic signed [31:0] pair;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic              cap_centre;
    logic              add_nb;
    logic              term_start;
  } lane_ctrl_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    ovf;
    logic                    done;
  } lane_res_t;

  typedef struct packed {
    logic signed [31:0] dp_a;
    logic signed [31:0] dp_b;
    logic signed [31:0] dp_c;
    logic signed [31:0] q;
    logic               ovf;
    logic               done;
  } sc_res_t;

  // Floor of a Q8.24 product shifted back by 24 bits, clipped to the 32-bit range.
  function automatic satq_t shift_sat(input logic signed [71:0] prod);
    logic signed [47:0] sh;
    satq_t              r;
    sh    = prod[71:24];
    r.ovf = !((&sh[47:31]) || !(|sh[47:31]));
    if (r.ovf) begin
      r.val = sh[47] ? Q_MIN : Q_MAX;
    end else begin
      r.val = sh[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/psf_lane.sv @@
`default_nettype none
module psf_lane (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire psf_pkg::lane_ctrl_t  ctrl,
  input  wire logic signed [31:0]   wdata,
  input  wire psf_pkg::cfg_t        cfg,
  input  wire logic signed [31:0]   p_other_a,
  input  wire logic signed [31:0]   p_other_b,
  input  wire logic signed [31:0]   dp,
  input  wire logic signed [31:0]   q,
  output logic signed [31:0]        centre,
  output psf_pkg::lane_res_t        res
);
  import psf_pkg::*;

  typedef enum logic [1:0] {TERM_LAP, TERM_MASS, TERM_TRI, TERM_PAIR} term_t;

  logic [31:0]             mem [CELL_COUNT];
  logic signed [31:0]      rdata_r;
  logic signed [31:0]      centre_r;
  logic signed [LAP_W-1:0] lap_r;
  logic signed [LAP_W-1:0] rd_ext;
  logic signed [LAP_W-1:0] six;
  term_t                   term_r;
  term_t                   psel_r;
  logic                    busy_r;
  logic                    pv_r;
  logic signed [35:0]      mula;
  logic signed [32:0]      mulb;
  logic signed [68:0]      prod_r;
  satq_t                   ts;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] ts_ext;
  logic                    ovf_r;
  logic                    done_r;

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[ctrl.addr] <= wdata;
    end
    if (ctrl.re) begin
      rdata_r <= mem[ctrl.addr];
    end
  end

  assign rd_ext = LAP_W'(rdata_r);
  assign six    = (rd_ext <<< 2) + (rd_ext <<< 1);

  always_ff @(posedge clk) begin
    if (ctrl.cap_centre) begin
      centre_r <= rdata_r;
      lap_r    <= -six;
    end else if (ctrl.add_nb) begin
      lap_r <= lap_r + rd_ext;
    end
  end

  always_comb begin
    case (term_r)
      TERM_LAP: begin
        mula = lap_r;
        mulb = {2'b00, cfg.inv_sq};
      end
      TERM_MASS: begin
        mula = 36'(cfg.mass);
        mulb = 33'(centre_r);
      end
      TERM_TRI: begin
        mula = 36'(q);
        mulb = 33'(dp);
      end
      TERM_PAIR: begin
        mula = 36'(cfg.pair);
        mulb = 33'(p_other_a) + 33'(p_other_b);
      end
      default: begin
        mula = '0;
        mulb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mula * mulb;
    psel_r <= term_r;
  end

  assign ts     = shift_sat(72'(prod_r));
  assign ts_ext = SUM_W'(ts.val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      term_r <= TERM_LAP;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
      sum_r  <= '0;
    end else begin
      pv_r   <= busy_r;
      done_r <= pv_r && (psel_r == TERM_PAIR);
      if (ctrl.term_start) begin
        busy_r <= 1'b1;
        term_r <= TERM_LAP;
        sum_r  <= '0;
        ovf_r  <= 1'b0;
      end else begin
        if (busy_r) begin
          term_r <= term_t'(term_r + 2'd1);
          if (term_r == TERM_PAIR) begin
            busy_r <= 1'b0;
          end
        end
        if (pv_r) begin
          sum_r <= (psel_r == TERM_LAP) ? sum_r + ts_ext : sum_r - ts_ext;
          ovf_r <= ovf_r | ts.ovf;
        end
      end
    end
  end

  assign centre = centre_r;
  assign res    = {sum_r, ovf_r, done_r};

endmodule
`default_nettype wire

@@ hw/rtl/psf_scalar.sv @@
`default_nettype none
module psf_scalar (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] p_a,
  input  wire logic signed [31:0] p_b,
  input  wire logic signed [31:0] p_c,
  input  wire psf_pkg::cfg_t      cfg,
  output psf_pkg::sc_res_t        res
);
  import psf_pkg::*;

  typedef enum logic [1:0] {SC_IDLE, SC_MUL, SC_DIV} sc_state_t;
  typedef enum logic [2:0] {
    OP_DP_A, OP_DP_B, OP_DP_C, OP_P, OP_MUP, OP_P2, OP_KPP, OP_DEN2
  } op_t;

  localparam int DIV_W    = 60;
  localparam int DIV_STEP = 4;
  localparam int DIV_CYC  = DIV_W / DIV_STEP;

  sc_state_t          state_r;
  op_t                op_r;
  logic               ph_r;
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic signed [63:0] prod_r;
  satq_t              ms;
  logic signed [31:0] dp_a_r, dp_b_r, dp_c_r, p_r, mup_r, p2_r, den_r, den2_r, q_r;
  logic        [32:0] den_sum;
  logic               ovf_r;
  logic               done_r;
  logic [DIV_W-1:0]   qsh_r;
  logic [DIV_W-1:0]   qsh_nxt;
  logic [31:0]        rem_r;
  logic [31:0]        rem_nxt;
  logic [32:0]        rem_w;
  logic [$clog2(DIV_CYC+1)-1:0] cnt_r;
  logic               neg_r;
  logic [31:0]        mup_abs;

  always_comb begin
    case (op_r)
      OP_DP_A: begin opa = p_b;    opb = p_c;    end
      OP_DP_B: begin opa = p_a;    opb = p_c;    end
      OP_DP_C: begin opa = p_a;    opb = p_b;    end
      OP_P:    begin opa = dp_c_r; opb = p_c;    end
      OP_MUP:  begin opa = cfg.triple; opb = p_r; end
      OP_P2:   begin opa = p_r;    opb = p_r;    end
      OP_KPP:  begin opa = {1'b0, cfg.kappa}; opb = p2_r; end
      OP_DEN2: begin opa = den_r;  opb = den_r;  end
      default: begin opa = '0;     opb = '0;     end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
  end

  assign ms      = shift_sat(72'(prod_r));
  assign den_sum = 33'(Q_ONE) + 33'(ms.val);
  assign mup_abs = mup_r[31] ? 32'(-33'(mup_r)) : mup_r;

  // Restoring division, four quotient bits a cycle.
  always_comb begin
    qsh_nxt = qsh_r;
    rem_nxt = rem_r;
    rem_w   = '0;
    for (int s = 0; s < DIV_STEP; s++) begin
      rem_w   = {rem_nxt, qsh_nxt[DIV_W-1]};
      qsh_nxt = {qsh_nxt[DIV_W-2:0], 1'b0};
      if (rem_w >= {1'b0, den2_r}) begin
        rem_w      = rem_w - {1'b0, den2_r};
        qsh_nxt[0] = 1'b1;
      end
      rem_nxt = rem_w[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      op_r    <= OP_DP_A;
      ph_r    <= 1'b0;
      ovf_r   <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        SC_IDLE: begin
          if (start) begin
            state_r <= SC_MUL;
            op_r    <= OP_DP_A;
            ph_r    <= 1'b0;
            ovf_r   <= 1'b0;
          end
        end
        SC_MUL: begin
          ph_r <= !ph_r;
          if (ph_r) begin
            ovf_r <= ovf_r | ms.ovf;
            case (op_r)
              OP_DP_A: dp_a_r <= ms.val;
              OP_DP_B: dp_b_r <= ms.val;
              OP_DP_C: dp_c_r <= ms.val;
              OP_P:    p_r    <= ms.val;
              OP_MUP:  mup_r  <= ms.val;
              OP_P2:   p2_r   <= ms.val;
              OP_KPP: begin
                if (den_sum[32] != den_sum[31]) begin
                  den_r <= Q_MAX;
                  ovf_r <= 1'b1;
                end else begin
                  den_r <= den_sum[31:0];
                  ovf_r <= ovf_r | ms.ovf;
                end
              end
              OP_DEN2: den2_r <= ms.val;
              default: ;
            endcase
            if (op_r == OP_DEN2) begin
              state_r <= SC_DIV;
              qsh_r   <= {4'b0000, mup_abs, 24'b0};
              rem_r   <= '0;
              neg_r   <= mup_r[31];
              cnt_r   <= ($clog2(DIV_CYC+1))'(DIV_CYC);
            end else begin
              op_r <= op_t'(op_r + 3'd1);
            end
          end
        end
        SC_DIV: begin
          qsh_r <= qsh_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == 1) begin
            q_r     <= neg_r ? -qsh_nxt[31:0] : qsh_nxt[31:0];
            done_r  <= 1'b1;
            state_r <= SC_IDLE;
          end
        end
        default: state_r <= SC_IDLE;
      endcase
    end
  end

  assign res = {dp_a_r, dp_b_r, dp_c_r, q_r, ovf_r, done_r};

endmodule
`default_nettype wire

@@ hw/rtl/psf_merge.sv @@
`default_nettype none
module psf_merge (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  take,
  input  wire logic [11:0]           idx,
  input  wire psf_pkg::lane_res_t    res_a,
  input  wire psf_pkg::lane_res_t    res_b,
  input  wire psf_pkg::lane_res_t    res_c,
  input  wire logic                  sc_ovf,
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output logic [psf_pkg::TDATA_W-1:0] out_tdata,
  output logic                       out_tuser,
  output logic                       free
);
  import psf_pkg::*;

  function automatic satq_t clip(input logic signed [SUM_W-1:0] v);
    satq_t r;
    r.ovf = !((&v[SUM_W-1:31]) || !(|v[SUM_W-1:31]));
    r.val = r.ovf ? (v[SUM_W-1] ? Q_MIN : Q_MAX) : v[31:0];
    return r;
  endfunction

  satq_t ca, cb, cc;
  logic  valid_r;
  logic [TDATA_W-1:0] data_r;
  logic  flag_r;

  assign ca = clip(res_a.sum);
  assign cb = clip(res_b.sum);
  assign cc = clip(res_c.sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= {4'b0000, cc.val, cb.val, ca.val, idx};
      flag_r <= sc_ovf | res_a.ovf | res_b.ovf | res_c.ovf | ca.ovf | cb.ovf | cc.ovf;
    end
  end

  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = flag_r;

endmodule
`default_nettype wire

@@ hw/rtl/periodic_stencil_force.sv @@
// Force evaluation for three coupled scalar fields on a periodic cubic grid of
// GRID_SIDE cells a side, all in signed Q8.24. A load transaction writes the three
// field values of one cell and gives no result. A compute transaction reads the
// centre and six periodic neighbours of the named cell from three single-port
// field memories, one lane per field, one read a cycle, then a shared scalar unit
// forms the triple-product terms with one multiplier (eight products) and a
// restoring divider at four bits a cycle; each lane then forms its four scaled
// terms and a merge stage clips and packs the result. The input is taken again
// once the result is in the output register. The field memories are not cleared:
// a cell must be loaded, together with its neighbours, before it is computed.
// Indexes at or beyond the cell count are ignored. Configuration is written through
// the cfg_ port by the user only while no computation is in flight; the block
// itself does not enforce this.
`default_nettype none
module periodic_stencil_force (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // tdata: cell_index[11:0], value_a[43:12], value_b[75:44], value_c[107:76], zero fill
  input  wire logic [psf_pkg::TDATA_W-1:0]   in_tdata,
  // tuser: cmd (0 load, 1 compute)
  input  wire logic                          in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // tdata: out_index[11:0], accel_a[43:12], accel_b[75:44], accel_c[107:76], zero fill
  output logic [psf_pkg::TDATA_W-1:0]        out_tdata,
  // tuser: saturated
  output logic                               out_tuser,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [psf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);
  import psf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DEC_K, S_DEC_J, S_READ, S_SCALAR, S_TERMS, S_MERGE
  } state_t;

  typedef enum logic {CMD_LOAD = 1'b0, CMD_COMPUTE = 1'b1} cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_SPACING_SQ = 3'd0,
    REG_TRIPLE_COEFF   = 3'd1,
    REG_SAT_COEFF      = 3'd2,
    REG_MASS_SQUARED   = 3'd3,
    REG_PAIR_COEFF     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0]   quot;
    logic [COORD_W-1:0] rem;
  } divside_t;

  localparam int          RECIP_SH  = 24;
  localparam int          RECIP     = (1 << RECIP_SH) / GRID_SIDE;
  localparam logic [2:0]  STEP_LAST = 3'd7;

  // Division by the grid side: reciprocal estimate, then one correcting subtract.
  function automatic divside_t div_side(input logic [IDX_W-1:0] x);
    logic [IDX_W+RECIP_SH-1:0] prod;
    logic [IDX_W-1:0]          est;
    logic [IDX_W:0]            r;
    divside_t                  d;
    prod = (IDX_W+RECIP_SH)'(x) * (IDX_W+RECIP_SH)'(RECIP);
    est  = prod[IDX_W+RECIP_SH-1:RECIP_SH];
    r    = (IDX_W+1)'(x) - (IDX_W+1)'(int'(est) * GRID_SIDE);
    if (r >= (IDX_W+1)'(GRID_SIDE)) begin
      est = est + 1'b1;
      r   = r - (IDX_W+1)'(GRID_SIDE);
    end
    d.quot = est;
    d.rem  = r[COORD_W-1:0];
    return d;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] i,
                                                  input logic [COORD_W-1:0] j,
                                                  input logic [COORD_W-1:0] k);
    return ADDR_W'(int'(i) * PLANE + int'(j) * GRID_SIDE + int'(k));
  endfunction

  function automatic logic [COORD_W-1:0] up(input logic [COORD_W-1:0] c);
    return (int'(c) == GRID_SIDE - 1) ? '0 : c + 1'b1;
  endfunction

  function automatic logic [COORD_W-1:0] down(input logic [COORD_W-1:0] c);
    return (c == '0) ? COORD_W'(GRID_SIDE - 1) : c - 1'b1;
  endfunction

  state_t             state_r;
  cfg_t               cfg_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   q1_r;
  logic [COORD_W-1:0] i_r, j_r, k_r;
  logic [2:0]         step_r;
  logic               tag_valid_r;
  logic               tag_first_r;
  divside_t           dk, dj;
  logic [ADDR_W-1:0]  rd_addr;
  logic               in_take;
  logic [IDX_W-1:0]   in_idx;
  logic               in_range;
  cmd_t               in_cmd;
  logic               scal_start;
  logic               merge_free;
  logic               merge_take;
  lane_ctrl_t         ctrl;
  sc_res_t            sc;
  lane_res_t          res_a, res_b, res_c;
  logic signed [31:0] p_a, p_b, p_c;

  assign in_tready = (state_r == S_IDLE);
  assign in_take   = in_tvalid && in_tready;
  assign in_idx    = in_tdata[IDX_W-1:0];
  assign in_cmd    = cmd_t'(in_tuser);
  assign in_range  = int'(in_idx) < CELL_COUNT;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_sq <= 31'(Q_ONE);
      cfg_r.triple <= '0;
      cfg_r.kappa  <= '0;
      cfg_r.mass   <= '0;
      cfg_r.pair   <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_INV_SPACING_SQ: cfg_r.inv_sq <= cfg_data[30:0];
        REG_TRIPLE_COEFF:   cfg_r.triple <= cfg_data;
        REG_SAT_COEFF:      cfg_r.kappa  <= cfg_data[30:0];
        REG_MASS_SQUARED:   cfg_r.mass   <= cfg_data;
        REG_PAIR_COEFF:     cfg_r.pair   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dk = div_side(idx_r);
  assign dj = div_side(q1_r);

  // Centre first, then the six neighbours with wrap-around on each axis.
  always_comb begin
    case (step_r)
      3'd0:    rd_addr = idx_r[ADDR_W-1:0];
      3'd1:    rd_addr = cell_addr(up(i_r), j_r, k_r);
      3'd2:    rd_addr = cell_addr(down(i_r), j_r, k_r);
      3'd3:    rd_addr = cell_addr(i_r, up(j_r), k_r);
      3'd4:    rd_addr = cell_addr(i_r, down(j_r), k_r);
      3'd5:    rd_addr = cell_addr(i_r, j_r, up(k_r));
      3'd6:    rd_addr = cell_addr(i_r, j_r, down(k_r));
      default: rd_addr = idx_r[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    ctrl.we         = in_take && in_range && (in_cmd == CMD_LOAD);
    ctrl.re         = (state_r == S_READ) && (step_r != STEP_LAST);
    ctrl.addr       = (state_r == S_IDLE) ? in_idx[ADDR_W-1:0] : rd_addr;
    ctrl.cap_centre = tag_valid_r && tag_first_r;
    ctrl.add_nb     = tag_valid_r && !tag_first_r;
    ctrl.term_start = (state_r == S_SCALAR) && sc.done;
  end

  assign scal_start = (state_r == S_READ) && (step_r == STEP_LAST);
  assign merge_take = (state_r == S_MERGE) && merge_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      tag_valid_r <= 1'b0;
      tag_first_r <= 1'b0;
    end else begin
      tag_valid_r <= ctrl.re;
      tag_first_r <= (step_r == '0);
      case (state_r)
        S_IDLE: begin
          if (in_take && in_range && (in_cmd == CMD_COMPUTE)) begin
            state_r <= S_DEC_K;
          end
        end
        S_DEC_K: state_r <= S_DEC_J;
        S_DEC_J: begin
          state_r <= S_READ;
          step_r  <= '0;
        end
        S_READ: begin
          step_r <= step_r + 1'b1;
          if (step_r == STEP_LAST) begin
            state_r <= S_SCALAR;
          end
        end
        S_SCALAR: begin
          if (sc.done) begin
            state_r <= S_TERMS;
          end
        end
        S_TERMS: begin
          if (res_a.done) begin
            state_r <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (merge_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      idx_r <= in_idx;
    end
    if (state_r == S_DEC_K) begin
      q1_r <= dk.quot;
      k_r  <= dk.rem;
    end
    if (state_r == S_DEC_J) begin
      i_r <= dj.quot[COORD_W-1:0];
      j_r <= dj.rem;
    end
  end

  psf_lane u_lane_a (
    .clk, .rst_n, .ctrl, .wdata(in_tdata[43:12]), .cfg(cfg_r),
    .p_other_a(p_b), .p_other_b(p_c), .dp(sc.dp_a), .q(sc.q),
    .centre(p_a), .res(res_a)
  );

  psf_lane u_lane_b (
    .clk, .rst_n, .ctrl, .wdata(in_tdata[75:44]), .cfg(cfg_r),
    .p_other_a(p_c), .p_other_b(p_a), .dp(sc.dp_b), .q(sc.q),
    .centre(p_b), .res(res_b)
  );

  psf_lane u_lane_c (
    .clk, .rst_n, .ctrl, .wdata(in_tdata[107:76]), .cfg(cfg_r),
    .p_other_a(p_a), .p_other_b(p_b), .dp(sc.dp_c), .q(sc.q),
    .centre(p_c), .res(res_c)
  );

  psf_scalar u_scalar (
    .clk, .rst_n, .start(scal_start), .p_a, .p_b, .p_c, .cfg(cfg_r), .res(sc)
  );

  psf_merge u_merge (
    .clk, .rst_n, .take(merge_take), .idx(idx_r), .res_a, .res_b, .res_c,
    .sc_ovf(sc.ovf), .out_tready, .out_tvalid, .out_tdata, .out_tuser,
    .free(merge_free)
  );

  // The scalar unit only finishes while the sequencer waits for it.
  a_sc_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sc.done |-> state_r == S_SCALAR) else $error("scalar result outside its wait state");

  // All three lanes run in lock step.
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (res_a.done == res_b.done) && (res_a.done == res_c.done))
    else $error("lanes out of step");

  // A new result only appears after the merge stage was loaded.
  a_out_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(merge_take)) else $error("result without merge");

  // No new transaction is taken while a computation is in flight.
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ || state_r == S_SCALAR || state_r == S_TERMS) |-> !in_tready)
    else $error("input taken mid computation");

endmodule
`default_nettype wire

@@ bench/tb_periodic_stencil_force.sv @@
`timescale 1ns / 100ps
`default_nettype none
// Self-checking bench for the periodic stencil force block. Loads and computes are streamed
// in, each accepted compute is predicted here and every result is checked against the
// oldest prediction still waiting.
module tb_periodic_stencil_force;
  import psf_pkg::*;

  localparam bit CMD_LOAD    = 1'b0;
  localparam bit CMD_COMPUTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_INV_SQ = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIPLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KAPPA  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR   = 3'd4;

  localparam longint ONE_Q    = 64'sd16777216;
  localparam longint MAX_Q    = 64'sd2147483647;
  localparam longint MIN_Q    = -64'sd2147483648;
  localparam int     SETTLE   = 64;   // margin beyond the compute latency
  localparam int     LONG_HOLD = 300;
  localparam int     PHASES   = 6;
  localparam int     PER_PHASE = 200;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] acc_a;
    logic signed [31:0] acc_b;
    logic signed [31:0] acc_c;
    logic               clipped;
  } force_t;

  typedef struct {
    bit                 cmd;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] va, vb, vc;
    bit                 typed;    // expected force written into the row
    logic signed [31:0] ea, eb, ec;
    bit                 es;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  periodic_stencil_force u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow copy of the block: three field stores, which cells have been loaded, and the
  // five coefficients.
  logic signed [31:0] shadow_a [CELL_COUNT];
  logic signed [31:0] shadow_b [CELL_COUNT];
  logic signed [31:0] shadow_c [CELL_COUNT];
  bit                 loaded   [CELL_COUNT];
  longint inv_sq_q, triple_q, kappa_q, mass_q, pair_q;
  bit     clip_seen;

  force_t pending_forces[$];
  int     errors = 0;
  bit     quiet = 1'b0;       // no idling on either side in the closing phase
  bit     hold_req = 1'b0;    // asks the receiver for one long hold-off

  function automatic longint clip32(input logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF) begin
      clip_seen = 1'b1;
      return MAX_Q;
    end else if (v < -128'sh8000_0000) begin
      clip_seen = 1'b1;
      return MIN_Q;
    end
    return longint'(v);
  endfunction

  // Exact Q8.24 product, floored back by 24 bits and clipped.
  function automatic longint qmul(input longint x, input longint y);
    logic signed [127:0] p;
    p = x;
    p = p * y;
    return clip32(p >>> 24);
  endfunction

  function automatic int wrap_cell(input int i, input int j, input int k);
    return ((i + GRID_SIDE) % GRID_SIDE) * PLANE + ((j + GRID_SIDE) % GRID_SIDE) * GRID_SIDE
           + (k + GRID_SIDE) % GRID_SIDE;
  endfunction

  function automatic int neighbour(input int idx, input int n);
    int i, j, k;
    i = idx / PLANE;
    j = (idx / GRID_SIDE) % GRID_SIDE;
    k = idx % GRID_SIDE;
    case (n)
      0: return wrap_cell(i + 1, j, k);
      1: return wrap_cell(i - 1, j, k);
      2: return wrap_cell(i, j + 1, k);
      3: return wrap_cell(i, j - 1, k);
      4: return wrap_cell(i, j, k + 1);
      default: return wrap_cell(i, j, k - 1);
    endcase
  endfunction

  function automatic bit stencil_loaded(input int idx);
    bit ok;
    ok = loaded[idx];
    for (int n = 0; n < 6; n++) ok &= loaded[neighbour(idx, n)];
    return ok;
  endfunction

  function automatic longint field_at(input int f, input int idx);
    case (f)
      0: return longint'(shadow_a[idx]);
      1: return longint'(shadow_b[idx]);
      default: return longint'(shadow_c[idx]);
    endcase
  endfunction

  // Accelerations of all three fields at one cell.
  function automatic force_t stencil_force(input int idx);
    longint phi[3], dphi[3], acc[3];
    longint prod, mup, prod_sq, kpp, den, den_sq, quot, lap;
    force_t r;
    clip_seen = 1'b0;
    for (int f = 0; f < 3; f++) phi[f] = field_at(f, idx);
    dphi[0] = qmul(phi[1], phi[2]);
    dphi[1] = qmul(phi[0], phi[2]);
    dphi[2] = qmul(phi[0], phi[1]);
    prod    = qmul(dphi[2], phi[2]);
    mup     = qmul(triple_q, prod);
    prod_sq = qmul(prod, prod);
    kpp     = qmul(kappa_q, prod_sq);
    den     = clip32(ONE_Q + kpp);
    den_sq  = qmul(den, den);
    quot    = (mup * ONE_Q) / den_sq;
    for (int f = 0; f < 3; f++) begin
      lap = -6 * phi[f];
      for (int n = 0; n < 6; n++) lap += field_at(f, neighbour(idx, n));
      acc[f] = clip32(qmul(lap, inv_sq_q) - qmul(mass_q, phi[f]) - qmul(quot, dphi[f])
                      - qmul(pair_q, phi[(f + 1) % 3] + phi[(f + 2) % 3]));
    end
    r.idx = idx[IDX_W-1:0];
    r.acc_a = acc[0][31:0];
    r.acc_b = acc[1][31:0];
    r.acc_c = acc[2][31:0];
    r.clipped = clip_seen;
    return r;
  endfunction

  // Offers one item, sometimes with a random idle burst ahead of it, and updates the shadow state
  // once the transaction has gone through. A typed expectation replaces the prediction.
  task automatic send_item(input row_t r);
    force_t predicted;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.cmd;
    in_tdata  <= {4'b0, r.vc, r.vb, r.va, r.idx};
    do @(posedge clk); while (!in_tready);
    if (r.cmd == CMD_LOAD) begin
      shadow_a[r.idx] = r.va;
      shadow_b[r.idx] = r.vb;
      shadow_c[r.idx] = r.vc;
      loaded[r.idx] = 1'b1;
    end else begin
      predicted = stencil_force(r.idx);
      if (r.typed) begin
        predicted.acc_a = r.ea;
        predicted.acc_b = r.eb;
        predicted.acc_c = r.ec;
        predicted.clipped = r.es;
      end
      pending_forces.push_back(predicted);
    end
  endtask

  // Leaves cfg_valid high so that writes can follow back to back; the caller drops it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_INV_SQ: inv_sq_q = longint'({1'b0, val[30:0]});
      REG_TRIPLE: triple_q = longint'($signed(val));
      REG_KAPPA:  kappa_q  = longint'({1'b0, val[30:0]});
      REG_MASS:   mass_q   = longint'($signed(val));
      default:    pair_q   = longint'($signed(val));
    endcase
  endtask

  // Waits until every result is home and the block has had time to finish.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [31:0] field_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3, 4: return $signed($urandom);
      5: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      default: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
    endcase
  endfunction

  // Cells whose three coordinates are drawn from this set have their whole stencil
  // inside the same set once the coordinates 0, 1 and 15 are the centre.
  function automatic int cluster_coord(input bit centre);
    int near[5] = '{0, 1, 2, 14, 15};
    int mid[3]  = '{0, 1, 15};
    return centre ? mid[$urandom_range(0, 2)] : near[$urandom_range(0, 4)];
  endfunction

  function automatic row_t random_row();
    row_t r;
    int   idx;
    r = '{default: '0};
    r.va = field_value();
    r.vb = field_value();
    r.vc = field_value();
    case ($urandom_range(0, 19))
      0, 1: begin
        r.cmd = CMD_LOAD;
        r.idx = IDX_W'($urandom_range(0, CELL_COUNT - 1));
      end
      2: begin
        idx = $urandom_range(0, CELL_COUNT - 1);
        if (!stencil_loaded(idx)) idx = wrap_cell(cluster_coord(1), cluster_coord(1),
                                                  cluster_coord(1));
        r.cmd = CMD_COMPUTE;
        r.idx = IDX_W'(idx);
      end
      3, 4, 5, 6, 7, 8, 9: begin
        r.cmd = CMD_COMPUTE;
        r.idx = IDX_W'(wrap_cell(cluster_coord(1), cluster_coord(1), cluster_coord(1)));
      end
      default: begin
        r.cmd = CMD_LOAD;
        r.idx = IDX_W'(wrap_cell(cluster_coord(0), cluster_coord(0), cluster_coord(0)));
      end
    endcase
    return r;
  endfunction

  // Directed part around cell 0: its six neighbours at the positive extreme with a zero
  // centre, then at the negative extreme with the centre at the positive one, then all
  // zero neighbours with a centre of one. With the reset coefficients only the Laplacian
  // survives, so the forces can be written down directly.
  row_t directed[24];

  initial begin
    int nbrs[6] = '{256, 3840, 16, 240, 1, 15};
    for (int n = 0; n < 6; n++) begin
      directed[n]      = '{CMD_LOAD, IDX_W'(nbrs[n]), 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                           32'sh7FFF_FFFF, 1'b0, 0, 0, 0, 1'b0};
      directed[8 + n]  = '{CMD_LOAD, IDX_W'(nbrs[n]), 32'sh8000_0000, 32'sh8000_0000,
                           32'sh8000_0000, 1'b0, 0, 0, 0, 1'b0};
      directed[16 + n] = '{CMD_LOAD, IDX_W'(nbrs[n]), 0, 0, 0, 1'b0, 0, 0, 0, 1'b0};
    end
    directed[6]  = '{CMD_LOAD, '0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0};
    directed[7]  = '{CMD_COMPUTE, '0, 0, 0, 0, 1'b1,
                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1};
    directed[14] = '{CMD_LOAD, '0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     1'b0, 0, 0, 0, 1'b0};
    directed[15] = '{CMD_COMPUTE, '0, 0, 0, 0, 1'b1,
                     32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1};
    directed[22] = '{CMD_LOAD, '0, 32'sd16777216, 32'sd16777216, 32'sd16777216,
                     1'b0, 0, 0, 0, 1'b0};
    directed[23] = '{CMD_COMPUTE, '0, 0, 0, 0, 1'b1,
                     -32'sd100663296, -32'sd100663296, -32'sd100663296, 1'b0};
  end

  // Receiver: checks each result as its transaction completes, then picks the next
  // value of out_tready. Idle bursts and the long hold-off are counted here.
  int gap_left = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    force_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[11:0], out_tdata[43:12], out_tdata[75:44], out_tdata[107:76],
              out_tuser};
      if (pending_forces.size() == 0) begin
        $display("%0t: result for cell %0d arrived with nothing expected", $time, got.idx);
        errors++;
      end else begin
        want = pending_forces.pop_front();
        if (got.idx !== want.idx) begin
          $display("%0t: out_index expected %0d got %0d", $time, want.idx, got.idx);
          errors++;
        end
        if (got.acc_a !== want.acc_a) begin
          $display("%0t: accel_a expected %0d got %0d", $time, want.acc_a, got.acc_a);
          errors++;
        end
        if (got.acc_b !== want.acc_b) begin
          $display("%0t: accel_b expected %0d got %0d", $time, want.acc_b, got.acc_b);
          errors++;
        end
        if (got.acc_c !== want.acc_c) begin
          $display("%0t: accel_c expected %0d got %0d", $time, want.acc_c, got.acc_c);
          errors++;
        end
        if (got.clipped !== want.clipped) begin
          $display("%0t: saturated expected %0b got %0b", $time, want.clipped, got.clipped);
          errors++;
        end
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      gap_left = $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n;
    end
  end

  initial begin
    row_t r;
    inv_sq_q = ONE_Q;
    triple_q = 0;
    kappa_q  = 0;
    mass_q   = 0;
    pair_q   = 0;
    foreach (loaded[n]) loaded[n] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[n]) send_item(directed[n]);

    // Fill the whole cluster so that every centre in it can be computed from here on.
    foreach (loaded[n]) begin
      if ((n / PLANE) inside {0, 1, 2, 14, 15} && ((n / GRID_SIDE) % GRID_SIDE) inside
          {0, 1, 2, 14, 15} && (n % GRID_SIDE) inside {0, 1, 2, 14, 15}) begin
        r = '{CMD_LOAD, IDX_W'(n), field_value(), field_value(), field_value(), 1'b0,
              0, 0, 0, 1'b0};
        send_item(r);
      end
    end

    // Each phase runs under its own coefficient set, written only with the block idle.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: ;  // reset coefficients
        1: begin
          write_reg(REG_INV_SQ, 32'h0100_0000);
          write_reg(REG_TRIPLE, 32'h0100_0000);
          write_reg(REG_KAPPA,  32'h0100_0000);
          write_reg(REG_MASS,   32'h0080_0000);
          write_reg(REG_PAIR,   32'h0040_0000);
          hold_req = 1'b1;
        end
        2: begin
          write_reg(REG_INV_SQ, 32'h7FFF_FFFF);
          write_reg(REG_TRIPLE, 32'h8000_0000);
          write_reg(REG_KAPPA,  32'h7FFF_FFFF);
          write_reg(REG_MASS,   32'h7FFF_FFFF);
          write_reg(REG_PAIR,   32'h8000_0000);
        end
        3: begin
          write_reg(REG_INV_SQ, 32'h0000_0000);
          write_reg(REG_TRIPLE, 32'h7FFF_FFFF);
          write_reg(REG_KAPPA,  32'h0000_0000);
          write_reg(REG_MASS,   32'h8000_0000);
          write_reg(REG_PAIR,   32'h7FFF_FFFF);
        end
        4: begin
          write_reg(REG_INV_SQ, $urandom);
          write_reg(REG_TRIPLE, $urandom);
          write_reg(REG_KAPPA,  $urandom);
          write_reg(REG_MASS,   $urandom);
          write_reg(REG_PAIR,   $urandom);
        end
        default: begin
          write_reg(REG_INV_SQ, $urandom_range(0, 32'h0400_0000));
          write_reg(REG_TRIPLE, $urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
          write_reg(REG_KAPPA,  $urandom_range(0, 32'h0200_0000));
          write_reg(REG_MASS,   $urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
          write_reg(REG_PAIR,   $urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
          quiet = 1'b1;
        end
      endcase
      cfg_valid <= 1'b0;
      repeat (PER_PHASE) send_item(random_row());
    end

    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
